// ===== design/desq_pkg.sv =====
package desq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned ENTRY_W = 72;

	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_REAR = 3'd1;
	localparam logic [2:0] FN_POP_FRONT = 3'd2;
	localparam logic [2:0] FN_POP_REAR = 3'd3;
	localparam logic [2:0] FN_COUNT = 3'd4;
	localparam logic [2:0] FN_DUMP = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_PUSH = 4'd1;
	localparam logic [3:0] OP_FULL = 4'd2;
	localparam logic [3:0] OP_EMPTY = 4'd3;
	localparam logic [3:0] OP_PLAIN = 4'd4;
	localparam logic [3:0] OP_POP = 4'd5;
	localparam logic [3:0] OP_POP_OUT = 4'd6;
	localparam logic [3:0] OP_DUMP_FIRST = 4'd7;
	localparam logic [3:0] OP_DUMP_STEP = 4'd8;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] text_low;
		logic [7:0]  text_high;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] data_low;
		logic [7:0]  data_high;
		logic [4:0]  entry_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic       latch;
		logic [3:0] op;
	} ctl_t;

	typedef struct packed {
		logic [2:0] func;
		logic       empty;
		logic       full;
		logic       dump_last;
	} sts_t;

endpackage

// ===== design/desq_ctrl.sv =====
module desq_ctrl import desq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP_OUT = 2'd2;
	localparam logic [1:0] S_DUMP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl.latch = 1'b0;
		ctl.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nx = S_IDLE;
				case (sts.func)
					FN_PUSH_FRONT, FN_PUSH_REAR: begin
						ctl.op = sts.full ? OP_FULL : OP_PUSH;
					end
					FN_POP_FRONT, FN_POP_REAR: begin
						if (sts.empty) begin
							ctl.op = OP_EMPTY;
						end else begin
							ctl.op = OP_POP;
							state_nx = S_POP_OUT;
						end
					end
					FN_COUNT: begin
						ctl.op = sts.empty ? OP_EMPTY : OP_PLAIN;
					end
					FN_DUMP: begin
						if (sts.empty) begin
							ctl.op = OP_EMPTY;
						end else begin
							ctl.op = OP_DUMP_FIRST;
							state_nx = S_DUMP;
						end
					end
					default: begin
						ctl.op = OP_PLAIN;
					end
				endcase
			end
			S_POP_OUT: begin
				ctl.op = OP_POP_OUT;
				state_nx = S_IDLE;
			end
			S_DUMP: begin
				ctl.op = OP_DUMP_STEP;
				if (sts.dump_last) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== design/desq_datapath.sv =====
module desq_datapath import desq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t cmd,
	input  ctl_t ctl,
	output sts_t sts,
	output logic done,
	output rsp_t rsp
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned OW = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] text_q;
	logic [ENTRY_W-1:0] data_q;
	logic [2:0]         func_q;
	logic [PW-1:0]      front_q;
	logic [OW-1:0]      occ_q;
	logic [OW-1:0]      idx_q;
	logic [1:0]         status_q;
	logic               last_q;
	logic               done_q;

	logic [PW-1:0]      front_inc;
	logic [PW-1:0]      front_dec;
	logic [OW-1:0]      off;
	logic [PW:0]        sum;
	logic [PW-1:0]      slot;
	logic               wr_en;
	logic [PW-1:0]      wr_addr;
	logic               rd_en;
	logic [PW-1:0]      rd_addr;
	logic               emit;
	logic               dump_last;

	assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - 1'b1;
	assign dump_last = (idx_q == occ_q);

	always_comb begin
		case (ctl.op)
			OP_PUSH:      off = occ_q;
			OP_POP:       off = occ_q - 1'b1;
			OP_DUMP_STEP: off = idx_q;
			default:      off = '0;
		endcase
	end

	assign sum = {1'b0, front_q} + (PW + 1)'(off);
	assign slot = (sum >= (PW + 1)'(DEPTH)) ? PW'(sum - (PW + 1)'(DEPTH)) : PW'(sum);

	assign wr_en = (ctl.op == OP_PUSH);
	assign wr_addr = (func_q == FN_PUSH_FRONT) ? front_dec : slot;
	assign rd_en = (ctl.op == OP_POP) || (ctl.op == OP_DUMP_FIRST)
		|| ((ctl.op == OP_DUMP_STEP) && !dump_last);
	assign rd_addr = ((ctl.op == OP_POP) && (func_q == FN_POP_FRONT)) ? front_q : slot;

	assign emit = (ctl.op == OP_PUSH) || (ctl.op == OP_FULL) || (ctl.op == OP_EMPTY)
		|| (ctl.op == OP_PLAIN) || (ctl.op == OP_POP_OUT) || (ctl.op == OP_DUMP_STEP);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= text_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			if (ctl.op == OP_PUSH) begin
				occ_q <= occ_q + 1'b1;
				if (func_q == FN_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (ctl.op == OP_POP) begin
				occ_q <= occ_q - 1'b1;
				if (func_q == FN_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			func_q <= cmd.func;
			text_q <= {cmd.text_high, cmd.text_low};
		end
		case (ctl.op)
			OP_FULL: begin
				status_q <= ST_FULL;
				data_q <= '0;
				last_q <= 1'b1;
			end
			OP_EMPTY: begin
				status_q <= ST_EMPTY;
				data_q <= '0;
				last_q <= 1'b1;
			end
			OP_PUSH, OP_PLAIN: begin
				status_q <= ST_OK;
				data_q <= '0;
				last_q <= 1'b1;
			end
			OP_POP_OUT: begin
				status_q <= ST_OK;
				data_q <= rd_q;
				last_q <= 1'b1;
			end
			OP_DUMP_FIRST: begin
				idx_q <= OW'(1);
			end
			OP_DUMP_STEP: begin
				status_q <= ST_OK;
				data_q <= rd_q;
				last_q <= dump_last;
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sts.func = func_q;
	assign sts.empty = (occ_q == '0);
	assign sts.full = (occ_q == OW'(DEPTH));
	assign sts.dump_last = dump_last;

	assign done = done_q;
	assign rsp.status = status_q;
	assign rsp.data_low = data_q[63:0];
	assign rsp.data_high = data_q[71:64];
	assign rsp.entry_count = 5'(occ_q);
	assign rsp.last = last_q;

endmodule

// ===== design/double_ended_string_queue.sv =====
// Bounded double-ended queue of nine-character text entries held in a ring buffer.
// An item is accepted on a rising edge where start is high and busy is low; cmd
// carries the function code and the entry text for pushes.
// Every result appears on rsp for exactly one cycle with done high, and the
// receiver must take it then, since it cannot stall the block.
// Push, count, and any refused or empty request give one result, registered
// from the execute state. A pop reads the entry memory in the execute state and
// gives its result from the pop-output state. A dump of n entries reads the
// first entry in the execute state and then gives one result per cycle, with last on the final
// one; the memory's single registered read port sets that pace.
// busy falls in the cycle that shows the final result, so the next item can be
// taken on the same edge that takes that result: an item occupies the block
// while the controller is in execute, pop output (pop) or dump (dump).
// Reset empties the queue and sets the front index to zero; entry contents are
// not cleared, and only written entries are ever read back.
module double_ended_string_queue import desq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t cmd,
	output logic done,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	desq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	desq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== design/desq_checker.sv =====
module desq_checker import desq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// An accepted item keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted item");

	// No result can appear in the cycle right after acceptance.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result shown too early");

	// Dump results come back to back until the last one.
	a_dump_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.last) |=> done)
		else $error("gap inside a dump");

	// A refused or empty request ends its item at once.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |-> rsp.last)
		else $error("error status not on a final result");

	// A refused push only happens with the queue full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_FULL)) |-> (rsp.entry_count == 5'(DEPTH)))
		else $error("full status with a count below depth");

endmodule

bind double_ended_string_queue desq_checker #(
	.DEPTH (DEPTH)
) u_desq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== test/tb_double_ended_string_queue.sv =====
module tb_double_ended_string_queue import desq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	logic [63:0] slot_lo [QDEPTH];
	logic [7:0] slot_hi [QDEPTH];
	int head_idx = 0;
	int fill = 0;
	rsp_t pending_rsp [$];

	int cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int dumps_seen = 0;
	int refused_pushes = 0;
	int empty_hits = 0;
	bit steady = 1'b0;

	double_ended_string_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_double_ended_string_queue: done, errors");
			$finish;
		end
	end

	function automatic void deque_apply(req_t r);
		rsp_t e;
		int s;
		int k;
		e = '0;
		e.status = ST_OK;
		e.last = 1'b1;
		case (r.func)
			FN_PUSH_FRONT, FN_PUSH_REAR: begin
				if (fill >= QDEPTH) begin
					e.status = ST_FULL;
					refused_pushes++;
				end else begin
					if (r.func == FN_PUSH_FRONT) begin
						head_idx = (head_idx + QDEPTH - 1) % QDEPTH;
						s = head_idx;
					end else begin
						s = (head_idx + fill) % QDEPTH;
					end
					slot_lo[s] = r.text_low;
					slot_hi[s] = r.text_high;
					fill++;
				end
			end
			FN_POP_FRONT, FN_POP_REAR: begin
				if (fill == 0) begin
					e.status = ST_EMPTY;
					empty_hits++;
				end else begin
					if (r.func == FN_POP_FRONT) begin
						s = head_idx;
						head_idx = (head_idx + 1) % QDEPTH;
					end else begin
						s = (head_idx + fill - 1) % QDEPTH;
					end
					e.data_low = slot_lo[s];
					e.data_high = slot_hi[s];
					fill--;
				end
			end
			FN_COUNT: begin
				if (fill == 0)
					e.status = ST_EMPTY;
			end
			FN_DUMP: begin
				dumps_seen++;
				if (fill == 0) begin
					e.status = ST_EMPTY;
				end else begin
					for (k = 0; k < fill - 1; k++) begin
						s = (head_idx + k) % QDEPTH;
						e.data_low = slot_lo[s];
						e.data_high = slot_hi[s];
						e.entry_count = 5'(fill);
						e.last = 1'b0;
						pending_rsp.push_back(e);
					end
					s = (head_idx + fill - 1) % QDEPTH;
					e.data_low = slot_lo[s];
					e.data_high = slot_hi[s];
					e.last = 1'b1;
				end
			end
			default: ;
		endcase
		e.entry_count = 5'(fill);
		pending_rsp.push_back(e);
	endfunction

	function automatic void check_result(rsp_t got);
		rsp_t want;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result st=%0d lo=%h hi=%h cnt=%0d last=%b", $time,
				got.status, got.data_low, got.data_high, got.entry_count, got.last);
			return;
		end
		want = pending_rsp.pop_front();
		results_checked++;
		if (got.status !== want.status || got.data_low !== want.data_low ||
			got.data_high !== want.data_high || got.entry_count !== want.entry_count ||
			got.last !== want.last) begin
			mismatches++;
			$display("%0t: mismatch expected st=%0d lo=%h hi=%h cnt=%0d last=%b", $time,
				want.status, want.data_low, want.data_high, want.entry_count, want.last);
			$display("%0t:          actual   st=%0d lo=%h hi=%h cnt=%0d last=%b", $time,
				got.status, got.data_low, got.data_high, got.entry_count, got.last);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_result(rsp);
			if (start && !busy)
				deque_apply(cmd);
		end
	end

	function automatic req_t make_req(logic [2:0] f);
		req_t r;
		int n;
		r.func = f;
		r.text_low = {$urandom, $urandom};
		r.text_high = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, 9);
			if (n < 9)
				r.text_high = '0;
			if (n < 8)
				r.text_low = r.text_low & ((64'd1 << (8 * n)) - 64'd1);
		end
		return r;
	endfunction

	task automatic send_item(req_t r);
		int pick;
		int n;
		start <= 1'b1;
		cmd <= r;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		items_sent++;
		n = 0;
		if (!steady) begin
			pick = $urandom_range(0, 9);
			if (pick >= 9)
				n = $urandom_range(4, 25);
			else if (pick >= 6)
				n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			start <= 1'b0;
			cmd <= make_req(3'($urandom));
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		req_t r;
		send_item(make_req(FN_POP_FRONT));
		send_item(make_req(FN_POP_REAR));
		send_item(make_req(FN_COUNT));
		send_item(make_req(FN_DUMP));
		send_item(make_req(FN_SPARE_A));
		r = '{func: FN_PUSH_FRONT, text_low: '1, text_high: '1};
		send_item(r);
		r = '{func: FN_PUSH_REAR, text_low: '0, text_high: '0};
		send_item(r);
		r = '{func: FN_PUSH_FRONT, text_low: 64'h5555_aaaa_5555_aaaa, text_high: 8'ha5};
		send_item(r);
		r = '{func: FN_PUSH_REAR, text_low: 64'haaaa_5555_aaaa_5555, text_high: 8'h5a};
		send_item(r);
		send_item(make_req(FN_SPARE_B));
		send_item(make_req(FN_COUNT));
		send_item(make_req(FN_DUMP));
		send_item(make_req(FN_POP_REAR));
		send_item(make_req(FN_POP_FRONT));
		send_item(make_req(FN_POP_FRONT));
		send_item(make_req(FN_POP_REAR));
		send_item(make_req(FN_COUNT));
	endtask

	task automatic test_full_and_wrap();
		int i;
		for (i = 0; i < QDEPTH + 2; i++)
			send_item(make_req($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_REAR));
		send_item(make_req(FN_COUNT));
		send_item(make_req(FN_DUMP));
		for (i = 0; i < QDEPTH + 2; i++)
			send_item(make_req($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_REAR));
		send_item(make_req(FN_DUMP));
	endtask

	task automatic test_random_mix(int n_items);
		int i;
		int pick;
		int push_w;
		int pop_w;
		logic [2:0] f;
		for (i = 0; i < n_items; i++) begin
			if (i % 30 == 0)
				steady = ($urandom_range(0, 3) == 0);
			case ((i / 40) % 3)
				0: begin push_w = 60; pop_w = 20; end
				1: begin push_w = 20; pop_w = 60; end
				default: begin push_w = 40; pop_w = 40; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < push_w)
				f = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_REAR;
			else if (pick < push_w + pop_w)
				f = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_REAR;
			else if (pick < push_w + pop_w + 8)
				f = FN_DUMP;
			else if (pick < push_w + pop_w + 16)
				f = FN_COUNT;
			else
				f = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
			send_item(make_req(f));
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(115);
		test_full_and_wrap();
		test_random_mix(115);
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d items and %0d checked results: %0d dumps, %0d refused pushes,",
			items_sent, results_checked, dumps_seen, refused_pushes);
		$display("and %0d pops from an empty queue, with random gaps between items.",
			empty_hits);
		if (mismatches == 0)
			$display("tb_double_ended_string_queue: done, clean");
		else
			$display("tb_double_ended_string_queue: done, errors");
		$finish;
	end

endmodule
